FILE: rtl/fbwc_pkg.sv
// Shared types, constants and helpers for the framebuffer write block with cursor overlay.
package fbwc_pkg;

    localparam int CURSOR_W_DEF = 32;
    localparam int CURSOR_H_DEF = 32;
    localparam int IMAGE_DEPTH  = 1024;
    localparam int IMG_AW       = $clog2(IMAGE_DEPTH);
    localparam int CFG_IDX_W    = 3;

    localparam logic [7:0] MASK_RB = 8'hF8;
    localparam logic [7:0] MASK_G  = 8'hFC;

    typedef enum logic [1:0] {
        FMT_32 = 2'd0,
        FMT_24 = 2'd1,
        FMT_16 = 2'd2
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT = 3'd0,
        REG_STRIDE = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_LEFT   = 3'd4,
        REG_TOP    = 3'd5,
        REG_KEY    = 3'd6,
        REG_BASE   = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_LOAD  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [15:0] line_stride_bytes;
        logic [12:0] visible_width;
        logic [12:0] visible_height;
        logic [11:0] cursor_left;
        logic [11:0] cursor_top;
        logic [31:0] transparent_key;
        logic [31:0] frame_base;
    } cfg_t;

    function automatic logic [2:0] fmt_bytes(input logic [1:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_24:  n = 3'd3;
            FMT_16:  n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/fbwc_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
module fbwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fbwc_cfg.sv
// Configuration register file for the framebuffer write block.
module fbwc_cfg
    import fbwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FORMAT: cfg_next.pixel_format      = cfg_data[1:0];
                REG_STRIDE: cfg_next.line_stride_bytes = cfg_data[15:0];
                REG_WIDTH:  cfg_next.visible_width     = cfg_data[12:0];
                REG_HEIGHT: cfg_next.visible_height    = cfg_data[12:0];
                REG_LEFT:   cfg_next.cursor_left       = cfg_data[11:0];
                REG_TOP:    cfg_next.cursor_top        = cfg_data[11:0];
                REG_KEY:    cfg_next.transparent_key   = cfg_data;
                REG_BASE:   cfg_next.frame_base        = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/framebuffer_write_with_cursor_overlay_top.sv
// Top level: cursor overlay, pixel format conversion and framebuffer address generation.
// An accepted request passes through the stage-1 registers and then the output register.
// Throughput: 1 request per cycle when not stalled; the cursor image RAM is read once and written once per cycle.
// A cursor load written in one cycle is visible to a pixel accepted in the next cycle.
// Reset clears the configuration registers and pipeline valid bits; the cursor image is
// not cleared and must be loaded before the overlay is used.
module framebuffer_write_with_cursor_overlay_top
    import fbwc_pkg::*;
#(
    parameter int CURSOR_W = CURSOR_W_DEF,
    parameter int CURSOR_H = CURSOR_H_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [11:0]          pixel_col,
    input  logic [11:0]          pixel_row,
    input  logic [31:0]          color_word,
    input  logic [9:0]           cursor_slot,
    input  logic                 final_pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 write_enable,
    output logic [31:0]          byte_address,
    output logic [31:0]          out_data,
    output logic [2:0]           byte_count,
    output logic                 final_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CURSOR_AREA = CURSOR_W * CURSOR_H;
    localparam int IDX_W       = $clog2(CURSOR_AREA + CURSOR_W) + 1;

    cfg_t cfg;

    fbwc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic s1_valid_reg;
    logic s1_cmd_reg;
    logic s1_vis_reg;
    logic s1_ov_reg;
    logic [27:0] s1_prod_reg;
    logic [13:0] s1_colb_reg;
    logic [31:0] s1_color_reg;
    logic s1_fin_reg;

    logic out_valid_reg;
    logic out_we_reg;
    logic [31:0] out_addr_reg;
    logic [31:0] out_data_reg;
    logic [2:0] out_cnt_reg;
    logic out_fin_reg;

    logic out_free;
    logic s1_move;
    logic in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_take  = in_valid && (!s1_valid_reg || out_free);
    assign in_stall = s1_valid_reg && !out_free;

    logic is_load;
    logic vis;
    logic [11:0] dx;
    logic [11:0] dy;
    logic in_cur;
    logic [IDX_W-1:0] idx;
    logic ov;
    logic [13:0] colb;
    logic load_we;
    logic ram_re;
    logic [31:0] ram_rdata;

    always_comb
    begin
        is_load = (cmd_t'(cmd) == CMD_LOAD);
        vis = ({1'b0, pixel_col} < cfg.visible_width) && ({1'b0, pixel_row} < cfg.visible_height);
        dx = pixel_col - cfg.cursor_left;
        dy = pixel_row - cfg.cursor_top;
        in_cur = (pixel_col >= cfg.cursor_left) && (pixel_row >= cfg.cursor_top)
                 && (dx < 12'(CURSOR_W)) && (dy < 12'(CURSOR_H));
        idx = IDX_W'(dy) * IDX_W'(CURSOR_W) + IDX_W'(dx);
        ov = in_cur && (32'(idx) < IMAGE_DEPTH);
        unique case (cfg.pixel_format)
            FMT_24:  colb = {1'b0, pixel_col, 1'b0} + {2'b00, pixel_col};
            FMT_16:  colb = {1'b0, pixel_col, 1'b0};
            default: colb = {pixel_col, 2'b00};
        endcase
        load_we = in_take && is_load && (32'(cursor_slot) < CURSOR_AREA);
        ram_re  = in_take && !is_load && vis && ov;
    end

    fbwc_ram #(
        .WIDTH (32),
        .DEPTH (IMAGE_DEPTH)
    ) u_cursor_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (IMG_AW'(cursor_slot)),
        .wdata (color_word),
        .re    (ram_re),
        .raddr (IMG_AW'(idx)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg   <= is_load;
            s1_vis_reg   <= vis;
            s1_ov_reg    <= ov;
            s1_prod_reg  <= 28'(pixel_row) * 28'(cfg.line_stride_bytes);
            s1_colb_reg  <= colb;
            s1_color_reg <= color_word;
            s1_fin_reg   <= final_pixel;
        end
    end

    logic [31:0] px;
    logic [31:0] conv;
    logic [2:0] nbytes;
    logic draw;
    logic we_next;
    logic [31:0] addr_next;
    logic [31:0] data_next;
    logic fin_next;

    always_comb
    begin
        nbytes = fmt_bytes(cfg.pixel_format);
        px = (s1_ov_reg && (ram_rdata != cfg.transparent_key)) ? ram_rdata : s1_color_reg;
        unique case (nbytes)
            3'd2:    conv = {16'h0000, px[23:16] & MASK_RB, 8'h00}
                            | {21'h0, px[15:8] & MASK_G, 3'b000}
                            | {27'h0, px[7:3] & MASK_RB[7:3]};
            3'd3:    conv = {8'h00, px[23:0]};
            default: conv = px;
        endcase
        draw      = !s1_cmd_reg && s1_vis_reg;
        we_next   = draw;
        addr_next = draw ? cfg.frame_base + 32'(s1_prod_reg) + 32'(s1_colb_reg) : 32'h0;
        data_next = draw ? conv : 32'h0;
        fin_next  = !s1_cmd_reg && s1_fin_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_we_reg   <= we_next;
            out_addr_reg <= addr_next;
            out_data_reg <= data_next;
            out_cnt_reg  <= nbytes;
            out_fin_reg  <= fin_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = out_we_reg;
    assign byte_address = out_addr_reg;
    assign out_data     = out_data_reg;
    assign byte_count   = out_cnt_reg;
    assign final_out    = out_fin_reg;

endmodule

FILE: rtl/fbwc_checker.sv
// Port-level checker for the framebuffer write block, bound to the top level.
module fbwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        write_enable,
    input logic [31:0] byte_address,
    input logic [31:0] out_data,
    input logic [2:0]  byte_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> byte_address == 32'h0 && out_data == 32'h0)
        else $error("non-write result carries address or data");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count == 3'd2 || byte_count == 3'd3 || byte_count == 3'd4)
        else $error("illegal byte count");

    a_data_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 3'd2 |-> out_data[31:16] == 16'h0)
        else $error("16 bpp data exceeds two bytes");

endmodule

bind framebuffer_write_with_cursor_overlay_top fbwc_checker u_fbwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .byte_address (byte_address),
    .out_data     (out_data),
    .byte_count   (byte_count)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the framebuffer write block with cursor overlay.
`timescale 1ns / 1ps

module tb;
    import fbwc_pkg::*;

    localparam int CURSOR_W        = CURSOR_W_DEF;
    localparam int CURSOR_H        = CURSOR_H_DEF;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int RUN_LIMIT       = 400000;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    typedef struct packed {
        cmd_t        cmd;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] color;
        logic [9:0]  slot;
        logic        fin;
    } draw_req_t;

    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        fin;
    } fb_write_t;

    class fb_write_tracker;
        cfg_t        regs = '0;
        logic [31:0] cursor_words [IMAGE_DEPTH];
        bit          word_loaded [IMAGE_DEPTH];
        fb_write_t   pending_writes [$];
        int          errors = 0;

        function void set_reg(cfg_reg_t idx, logic [31:0] v);
            case (idx)
                REG_FORMAT: regs.pixel_format      = v[1:0];
                REG_STRIDE: regs.line_stride_bytes = v[15:0];
                REG_WIDTH:  regs.visible_width     = v[12:0];
                REG_HEIGHT: regs.visible_height    = v[12:0];
                REG_LEFT:   regs.cursor_left       = v[11:0];
                REG_TOP:    regs.cursor_top        = v[11:0];
                REG_KEY:    regs.transparent_key   = v;
                REG_BASE:   regs.frame_base        = v;
                default: ;
            endcase
        endfunction

        function bit on_screen(logic [11:0] col, logic [11:0] row);
            return ({1'b0, col} < regs.visible_width) && ({1'b0, row} < regs.visible_height);
        endfunction

        function bit in_cursor(input logic [11:0] col, input logic [11:0] row,
                               output int unsigned idx);
            int unsigned dx, dy;
            idx = 0;
            if (col < regs.cursor_left || row < regs.cursor_top)
                return 0;
            dx = col - regs.cursor_left;
            dy = row - regs.cursor_top;
            if (dx >= CURSOR_W || dy >= CURSOR_H)
                return 0;
            idx = dy * CURSOR_W + dx;
            return idx < IMAGE_DEPTH;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        function void note_request(draw_req_t r);
            fb_write_t   w;
            logic [31:0] px;
            logic [31:0] nb;
            int unsigned idx;
            case (regs.pixel_format)
                FMT_24:  nb = 3;
                FMT_16:  nb = 2;
                default: nb = 4;
            endcase
            w = '0;
            w.nbytes = nb[2:0];
            if (r.cmd == CMD_LOAD) begin
                if (r.slot < CURSOR_W * CURSOR_H) begin
                    cursor_words[r.slot] = r.color;
                    word_loaded[r.slot]  = 1'b1;
                end
            end
            else begin
                w.fin = r.fin;
                if (on_screen(r.col, r.row)) begin
                    px = r.color;
                    if (in_cursor(r.col, r.row, idx) && cursor_words[idx] != regs.transparent_key)
                        px = cursor_words[idx];
                    case (regs.pixel_format)
                        FMT_24:  w.data = {8'h00, px[23:0]};
                        FMT_16:  w.data = {16'h0000, px[23:19], px[15:10], px[7:3]};
                        default: w.data = px;
                    endcase
                    w.addr = regs.frame_base + 32'(r.row) * 32'(regs.line_stride_bytes)
                             + 32'(r.col) * nb;
                    w.we = 1'b1;
                end
            end
            pending_writes.push_back(w);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_write(fb_write_t got);
            fb_write_t want;
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected result we=%0b addr=%h data=%h",
                                 got.we, got.addr, got.data));
                return;
            end
            want = pending_writes.pop_front();
            if (got.we !== want.we)
                report($sformatf("write_enable %0b, expected %0b", got.we, want.we));
            if (got.addr !== want.addr)
                report($sformatf("byte_address %h, expected %h", got.addr, want.addr));
            if (got.data !== want.data)
                report($sformatf("out_data %h, expected %h", got.data, want.data));
            if (got.nbytes !== want.nbytes)
                report($sformatf("byte_count %0d, expected %0d", got.nbytes, want.nbytes));
            if (got.fin !== want.fin)
                report($sformatf("final_out %0b, expected %0b", got.fin, want.fin));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic                 cmd         = 1'b0;
    logic [11:0]          pixel_col   = '0;
    logic [11:0]          pixel_row   = '0;
    logic [31:0]          color_word  = '0;
    logic [9:0]           cursor_slot = '0;
    logic                 final_pixel = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 write_enable;
    logic [31:0]          byte_address;
    logic [31:0]          out_data;
    logic [2:0]           byte_count;
    logic                 final_out;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [31:0]          cfg_data    = '0;

    fb_write_tracker tracker = new;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int unsigned     cycle_count    = 0;

    framebuffer_write_with_cursor_overlay_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .color_word   (color_word),
        .cursor_slot  (cursor_slot),
        .final_pixel  (final_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .byte_address (byte_address),
        .out_data     (out_data),
        .byte_count   (byte_count),
        .final_out    (final_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
            tracker.check_write({write_enable, byte_address, out_data, byte_count, final_out});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("[framebuffer_write_with_cursor_overlay_top] ERROR");
            $finish;
        end
    end

    function automatic draw_req_t req_of(cmd_t c, logic [11:0] col, logic [11:0] row,
                                         logic [31:0] color, logic [9:0] slot, logic fin);
        return '{c, col, row, color, slot, fin};
    endfunction

    function automatic logic [11:0] pick_coord(logic [11:0] anchor, logic [12:0] limit);
        logic [11:0] v;
        int unsigned mode;
        mode = $urandom_range(99);
        v = 12'($urandom);
        if (mode < 40)
            v = anchor + 12'($urandom_range(CURSOR_W - 1));
        else if (mode < 70) begin
            if (limit != 0)
                v = 12'($urandom_range(limit - 1));
        end
        else if (mode < 85) begin
            case ($urandom_range(4))
                0:       v = 12'(limit - 1);
                1:       v = 12'(limit);
                2:       v = '0;
                3:       v = anchor - 12'd1;
                default: v = anchor + 12'(CURSOR_W);
            endcase
        end
        return v;
    endfunction

    function automatic draw_req_t random_req();
        draw_req_t r;
        r.col   = 12'($urandom);
        r.row   = 12'($urandom);
        r.color = $urandom;
        r.slot  = 10'($urandom);
        r.fin   = ($urandom_range(5) == 0);
        if ($urandom_range(99) < 12) begin
            r.cmd = CMD_LOAD;
            if ($urandom_range(3) == 0)
                r.color = tracker.regs.transparent_key;
        end
        else begin
            r.cmd = CMD_PIXEL;
            r.col = pick_coord(tracker.regs.cursor_left, tracker.regs.visible_width);
            r.row = pick_coord(tracker.regs.cursor_top, tracker.regs.visible_height);
        end
        return r;
    endfunction

    function automatic cfg_t phase_setting(int p);
        cfg_t c;
        c.pixel_format      = 2'($urandom_range(3));
        c.line_stride_bytes = 16'($urandom);
        c.visible_width     = 13'($urandom_range(4096));
        c.visible_height    = 13'($urandom_range(4096));
        c.cursor_left       = 12'($urandom_range(c.visible_width));
        c.cursor_top        = 12'($urandom_range(c.visible_height));
        c.transparent_key   = $urandom;
        c.frame_base        = $urandom;
        case (p)
            0: c = '{FMT_16, 16'd1280, 13'd640, 13'd480, 12'd0, 12'd0,
                     32'h00FF00FF, 32'h10000000};
            1: c = '{FMT_32, 16'hFFFF, 13'd4096, 13'd4096, 12'hFFF, 12'hFFF,
                     32'hFFFFFFFF, 32'hFFFFFFFF};
            2: c = '{FMT_24, 16'd0, 13'd0, 13'd0, 12'd100, 12'd50, 32'h0, 32'h0};
            3: c = '{FMT_UNUSED, 16'd4096, 13'd1024, 13'd768, 12'd1000, 12'd740,
                     32'h0, 32'h80000000};
            4: c = '{FMT_16, 16'd1, 13'd1, 13'd1, 12'd0, 12'd0,
                     c.transparent_key, c.frame_base};
            5: c = '{FMT_24, 16'd5760, 13'd1920, 13'd1080, 12'd1900, 12'd1060,
                     c.transparent_key, c.frame_base};
            7: c = '{FMT_32, c.line_stride_bytes, 13'd4096, 13'd4096, 12'd0, 12'd4064,
                     c.transparent_key, c.frame_base};
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_req(input draw_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= r.cmd;
        pixel_col   <= r.col;
        pixel_row   <= r.row;
        color_word  <= r.color;
        cursor_slot <= r.slot;
        final_pixel <= r.fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(r);
    endtask

    task automatic drain(input int settle_cycles);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic load_setting(input cfg_t c);
        cfg_reg_t    idx;
        logic [31:0] v;
        idx = idx.first();
        do begin
            case (idx)
                REG_FORMAT: v = 32'(c.pixel_format);
                REG_STRIDE: v = 32'(c.line_stride_bytes);
                REG_WIDTH:  v = 32'(c.visible_width);
                REG_HEIGHT: v = 32'(c.visible_height);
                REG_LEFT:   v = 32'(c.cursor_left);
                REG_TOP:    v = 32'(c.cursor_top);
                REG_KEY:    v = c.transparent_key;
                default:    v = c.frame_base;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            tracker.set_reg(idx, v);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        draw_req_t   r;
        draw_req_t   fill;
        int unsigned idx;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain(4);
            load_setting(phase_setting(p));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (p == 0) begin
                send_req(req_of(CMD_LOAD, 12'd0, 12'd0, 32'hFFFFFFFF, 10'd0, 1'b0));
                send_req(req_of(CMD_LOAD, 12'd0, 12'd0, 32'h00FF00FF, 10'd1023, 1'b0));
                send_req(req_of(CMD_LOAD, 12'd0, 12'd0, 32'h00000000, 10'd31, 1'b0));
                send_req(req_of(CMD_LOAD, 12'd0, 12'd0, 32'h12345678, 10'd992, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd0, 12'd0, 32'h00000000, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd31, 12'd31, 32'hFFFFFFFF, 10'd0, 1'b1));
                send_req(req_of(CMD_PIXEL, 12'd31, 12'd0, 32'hA5A5A5A5, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd0, 12'd31, 32'h00000000, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd639, 12'd479, 32'hFFFFFFFF, 10'h3FF, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd640, 12'd0, 32'h00FFFFFF, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd0, 12'd480, 32'h00FFFFFF, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 10'h3FF, 1'b1));
                send_req(req_of(CMD_PIXEL, 12'd32, 12'd0, 32'h00F8FCF8, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd0, 12'd32, 32'h00070307, 10'd0, 1'b0));
                send_req(req_of(CMD_LOAD, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 10'd1023, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd31, 12'd31, 32'h00000000, 10'd0, 1'b0));
                send_req(req_of(CMD_LOAD, 12'd0, 12'd0, 32'h00FF00FF, 10'd0, 1'b1));
                send_req(req_of(CMD_PIXEL, 12'd0, 12'd0, 32'h00FFFFFF, 10'd0, 1'b0));
                send_req(req_of(CMD_PIXEL, 12'd100, 12'd100, 32'h00808080, 10'h3FF, 1'b0));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain(0);
                r = random_req();
                if (r.cmd == CMD_PIXEL && tracker.on_screen(r.col, r.row)
                        && tracker.in_cursor(r.col, r.row, idx) && !tracker.word_loaded[idx]) begin
                    fill = req_of(CMD_LOAD, r.col, r.row,
                                  ($urandom_range(3) == 0) ? tracker.regs.transparent_key
                                                           : $urandom,
                                  10'(idx), r.fin);
                    send_req(fill);
                end
                send_req(r);
            end
        end
        drain(8);
        if (tracker.errors == 0)
            $display("[framebuffer_write_with_cursor_overlay_top] OK");
        else
            $display("[framebuffer_write_with_cursor_overlay_top] ERROR");
        $finish;
    end

endmodule
